// ===== hdl/pbph_pkg.sv =====
// ----------------------------------------------------------------------------
// pbph_pkg
// Shared types, codes and constants of the program counter bucket profiler.
// ----------------------------------------------------------------------------
package pbph_pkg;

    localparam int ADDR_BITS_DEF = 16;

    localparam int PC_W    = 16;
    localparam int CYC_W   = 8;
    localparam int IDX_W   = 17;
    localparam int OP_W    = 2;
    localparam int INSTR_W = 32;
    localparam int TOTAL_W = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [OP_W-1:0] OP_RECORD     = 2'd0;
    localparam logic [OP_W-1:0] OP_READ       = 2'd1;
    localparam logic [OP_W-1:0] OP_READ_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_SIZE = 2'd2;

    localparam logic [PC_W-1:0] RANGE_LOW_RST   = 16'h0000;
    localparam logic [PC_W-1:0] RANGE_HIGH_RST  = 16'hffff;
    localparam logic [PC_W-1:0] BUCKET_SIZE_RST = 16'h0001;

    localparam logic [INSTR_W-1:0] INSTR_MAX = {INSTR_W{1'b1}};
    localparam logic [TOTAL_W-1:0] CYCLE_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [PC_W-1:0]  pc;
        logic [CYC_W-1:0] cycle_count;
        logic [IDX_W-1:0] entry_index;
    } req_t;

    typedef struct packed {
        logic [INSTR_W-1:0] instr_total;
        logic [TOTAL_W-1:0] cycle_total;
    } rsp_t;

endpackage

// ===== hdl/pc_bucket_profile_histogram.sv =====
// ----------------------------------------------------------------------------
// pc_bucket_profile_histogram
// Instruction profiler histogram: counts instructions and cycles per
// program counter bucket in two RAMs, with read and read-and-clear requests.
//
// Channel   Direction  Handshake               Payload
// request   in         start && !busy          req (op, pc, cycle_count, entry_index)
// result    out        done, one-cycle strobe  rsp (instr_total, cycle_total)
// config    in         cfg_valid && cfg_ready  cfg_index, cfg_data
//
// A record with bucket_size of 2 or more holds busy through S_DIV, S_FIX, S_READ
// and S_UPDATE, with S_DIV run by the one-bit-per-cycle remainder unit; other
// records and reads inside the store hold it through S_READ and S_UPDATE, reads
// beyond the store and unused ops not at all. A read result inside the store is
// registered on done from S_UPDATE, one beyond the store straight from S_IDLE.
// After reset a clearing pass of every entry holds busy. Results cannot be stalled.
// ----------------------------------------------------------------------------
module pc_bucket_profile_histogram
    import pbph_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  req_t                  req,
    output logic                  done,
    output rsp_t                  rsp,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH = (1 << ADDR_BITS) + 1;
    localparam int AW    = ADDR_BITS + 1;
    localparam int WW    = (ADDR_BITS > PC_W) ? ADDR_BITS : PC_W;
    localparam int CW    = (AW > IDX_W) ? AW : IDX_W;
    localparam int CNTW  = $clog2(ADDR_BITS + 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_FIX    = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_UPDATE = 3'd5;

    localparam logic [AW-1:0] OVF_ENTRY = AW'(1) << ADDR_BITS;
    localparam logic [AW-1:0] LAST_ENTRY = AW'(DEPTH - 1);

    logic [2:0]           state_reg, state_next;
    logic [AW-1:0]        clr_addr_reg, clr_addr_next;
    logic                 done_reg, done_next;
    logic [PC_W-1:0]      range_low_reg, range_high_reg, bucket_size_reg;
    logic [AW-1:0]        entry_reg, entry_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [CYC_W-1:0]     cyc_reg, cyc_next;
    logic [ADDR_BITS-1:0] a_reg, a_next;
    logic [ADDR_BITS-1:0] shf_reg, shf_next;
    logic [PC_W-1:0]      rem_reg, rem_next;
    logic [CNTW-1:0]      cnt_reg, cnt_next;
    rsp_t                 rsp_reg, rsp_next;

    logic                 accept;
    logic [WW-1:0]        pc_w;
    logic [ADDR_BITS-1:0] pc_a;
    logic                 in_range;
    logic [CW-1:0]        idx_w;
    logic                 idx_beyond;
    logic [PC_W:0]        trial;
    logic                 trial_ge;
    logic [WW-1:0]        bucket_w;
    logic [TOTAL_W:0]     cyc_sum;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [INSTR_W-1:0]   instr_wdata, instr_rdata;
    logic [TOTAL_W-1:0]   cycle_wdata, cycle_rdata;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    assign accept    = start && !busy;

    assign pc_w       = WW'(req.pc);
    assign pc_a       = pc_w[ADDR_BITS-1:0];
    assign in_range   = !((req.pc < range_low_reg) || (req.pc > range_high_reg));
    assign idx_w      = CW'(req.entry_index);
    assign idx_beyond = idx_w > CW'(OVF_ENTRY);

    assign trial    = {rem_reg, shf_reg[ADDR_BITS-1]};
    assign trial_ge = trial >= {1'b0, bucket_size_reg};
    assign bucket_w = WW'(a_reg) - WW'(rem_reg);
    assign cyc_sum  = {1'b0, cycle_rdata} + (TOTAL_W + 1)'(cyc_reg);

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        done_next     = 1'b0;
        entry_next    = entry_reg;
        op_next       = op_reg;
        cyc_next      = cyc_reg;
        a_next        = a_reg;
        shf_next      = shf_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        rsp_next      = rsp_reg;
        ram_we        = 1'b0;
        ram_waddr     = entry_reg;
        instr_wdata   = '0;
        cycle_wdata   = '0;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ENTRY)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = req.op;
                    cyc_next = req.cycle_count;
                    if (req.op == OP_RECORD)
                    begin
                        if (!in_range)
                        begin
                            entry_next = OVF_ENTRY;
                            state_next = S_READ;
                        end
                        else if (bucket_size_reg < PC_W'(2))
                        begin
                            entry_next = {1'b0, pc_a};
                            state_next = S_READ;
                        end
                        else
                        begin
                            a_next     = pc_a;
                            shf_next   = pc_a;
                            rem_next   = '0;
                            cnt_next   = CNTW'(ADDR_BITS - 1);
                            state_next = S_DIV;
                        end
                    end
                    else if ((req.op == OP_READ) || (req.op == OP_READ_CLEAR))
                    begin
                        if (idx_beyond)
                        begin
                            rsp_next  = '0;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            entry_next = idx_w[AW-1:0];
                            state_next = S_READ;
                        end
                    end
                end
            end
            S_DIV:
            begin
                rem_next = trial_ge ? PC_W'(trial - {1'b0, bucket_size_reg})
                                    : trial[PC_W-1:0];
                shf_next = shf_reg << 1;
                cnt_next = cnt_reg - CNTW'(1);
                if (cnt_reg == '0)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                entry_next = {1'b0, bucket_w[ADDR_BITS-1:0]};
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                state_next = S_IDLE;
                if (op_reg == OP_RECORD)
                begin
                    ram_we      = 1'b1;
                    instr_wdata = (instr_rdata == INSTR_MAX) ? INSTR_MAX
                                                             : instr_rdata + INSTR_W'(1);
                    cycle_wdata = cyc_sum[TOTAL_W] ? CYCLE_MAX : cyc_sum[TOTAL_W-1:0];
                end
                else
                begin
                    rsp_next.instr_total = instr_rdata;
                    rsp_next.cycle_total = cycle_rdata;
                    done_next            = 1'b1;
                    ram_we               = (op_reg == OP_READ_CLEAR);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_addr_reg    <= '0;
            done_reg        <= 1'b0;
            range_low_reg   <= RANGE_LOW_RST;
            range_high_reg  <= RANGE_HIGH_RST;
            bucket_size_reg <= BUCKET_SIZE_RST;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            done_reg     <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RANGE_LOW:   range_low_reg   <= cfg_data;
                    CFG_RANGE_HIGH:  range_high_reg  <= cfg_data;
                    CFG_BUCKET_SIZE: bucket_size_reg <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        op_reg    <= op_next;
        cyc_reg   <= cyc_next;
        a_reg     <= a_next;
        shf_reg   <= shf_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        rsp_reg   <= rsp_next;
    end

    pbph_ram #(
        .WIDTH (INSTR_W),
        .DEPTH (DEPTH)
    ) u_instr_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (instr_wdata),
        .raddr (entry_reg),
        .rdata (instr_rdata)
    );

    pbph_ram #(
        .WIDTH (TOTAL_W),
        .DEPTH (DEPTH)
    ) u_cycle_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cycle_wdata),
        .raddr (entry_reg),
        .rdata (cycle_rdata)
    );

endmodule

// ===== hdl/pbph_ram.sv =====
// ----------------------------------------------------------------------------
// pbph_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module pbph_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/pbph_checker.sv =====
// ----------------------------------------------------------------------------
// pbph_checker
// Port-level checks of the profiler's request and result timing.
// ----------------------------------------------------------------------------
module pbph_checker
    import pbph_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input req_t                  req,
    input logic                  done,
    input rsp_t                  rsp
);

    localparam int CW = (ADDR_BITS + 1 > IDX_W) ? ADDR_BITS + 1 : IDX_W;
    localparam logic [CW-1:0] OVF_IDX = CW'(1) << ADDR_BITS;

    logic acc_read;
    logic acc_beyond;

    assign acc_read   = start && !busy && ((req.op == OP_READ) || (req.op == OP_READ_CLEAR));
    assign acc_beyond = acc_read && (CW'(req.entry_index) > OVF_IDX);

    // Every result answers a read request accepted before it.
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(acc_read, 1) || $past(acc_read, 3)))
        else $error("result without a matching read request");

    // A result is only shown while the block is free for a new request.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // A record request always occupies the block.
    a_record_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.op == OP_RECORD)) |=> busy)
        else $error("record request did not raise busy");

    // An index beyond the store reads back as zero on the next cycle.
    a_beyond_zero: assert property (@(posedge clk) disable iff (!rst_n)
        acc_beyond |=> (done && (rsp == '0)))
        else $error("out-of-store read did not return zero");

endmodule

bind pc_bucket_profile_histogram pbph_checker #(.ADDR_BITS(ADDR_BITS)) u_pbph_checker (.*);

// ===== tb/pc_bucket_profile_histogram_tb.sv =====
// ----------------------------------------------------------------------------
// pc_bucket_profile_histogram_tb
// Self-checking bench for the program counter bucket profiler. A scoreboard
// keeps its own sparse copy of the instruction and cycle tallies, predicts
// every read request, and checks each result strobe in order. A short
// directed part covers the store edges, the overflow entry, indexes beyond
// the store, read-and-clear, the unused op code and an empty range.
// Randomized phases under several range and bucket settings follow.
// ----------------------------------------------------------------------------
module pc_bucket_profile_histogram_tb;
    import pbph_pkg::*;

    localparam int ADDR_BITS = 16;
    localparam int unsigned OVF_ENTRY = 1 << ADDR_BITS;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = ADDR_BITS + 8;
    localparam int QUIET_LIMIT = 200000;
    localparam int PHASE_COUNT = 6;
    localparam int PHASE_ITEMS = 160;

    class profile_tally;
        bit [INSTR_W-1:0] instr_tally [int unsigned];
        bit [TOTAL_W-1:0] cycle_tally [int unsigned];
        bit [PC_W-1:0] range_lo;
        bit [PC_W-1:0] range_hi;
        bit [PC_W-1:0] bucket_span;
        rsp_t pending_totals [$];
        int errors;

        function new();
            range_lo = RANGE_LOW_RST;
            range_hi = RANGE_HIGH_RST;
            bucket_span = BUCKET_SIZE_RST;
            errors = 0;
        endfunction

        function int unsigned entry_for_pc(logic [PC_W-1:0] pc);
            int unsigned a;
            if (pc < range_lo || pc > range_hi)
                return OVF_ENTRY;
            a = pc & (OVF_ENTRY - 1);
            if (bucket_span < 2)
                return a;
            return (a / bucket_span) * bucket_span;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_RANGE_LOW:   range_lo = value;
                CFG_RANGE_HIGH:  range_hi = value;
                CFG_BUCKET_SIZE: bucket_span = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_totals.size();
        endfunction

        function void report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endfunction

        function void note_request(req_t r);
            int unsigned e;
            rsp_t res;
            bit [TOTAL_W:0] sum;
            case (r.op)
                OP_RECORD:
                begin
                    e = entry_for_pc(r.pc);
                    if (!instr_tally.exists(e))
                    begin
                        instr_tally[e] = '0;
                        cycle_tally[e] = '0;
                    end
                    if (instr_tally[e] != INSTR_MAX)
                        instr_tally[e] = instr_tally[e] + 1;
                    sum = {1'b0, cycle_tally[e]} + r.cycle_count;
                    cycle_tally[e] = (sum > CYCLE_MAX) ? CYCLE_MAX : sum[TOTAL_W-1:0];
                end
                OP_READ, OP_READ_CLEAR:
                begin
                    res = '0;
                    e = r.entry_index;
                    if (e <= OVF_ENTRY && instr_tally.exists(e))
                    begin
                        res.instr_total = instr_tally[e];
                        res.cycle_total = cycle_tally[e];
                        if (r.op == OP_READ_CLEAR)
                        begin
                            instr_tally.delete(e);
                            cycle_tally.delete(e);
                        end
                    end
                    pending_totals.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (pending_totals.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result instr %0d cycles %0d",
                                          got.instr_total, got.cycle_total));
                return;
            end
            want = pending_totals.pop_front();
            if (got.instr_total !== want.instr_total)
                report_mismatch($sformatf("instr_total %0d, want %0d",
                                          got.instr_total, want.instr_total));
            if (got.cycle_total !== want.cycle_total)
                report_mismatch($sformatf("cycle_total %0d, want %0d",
                                          got.cycle_total, want.cycle_total));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    req_t req = '0;
    logic done;
    rsp_t rsp;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    profile_tally tally = new();
    int gap_pct = 24;
    int quiet_cycles = 0;
    logic [PC_W-1:0] recent_pcs [$];

    // Range low, range high and bucket size of each random phase.
    logic [PC_W-1:0] phase_cfg [PHASE_COUNT][3] = '{
        '{16'h0000, 16'hffff, 16'h0001},
        '{16'h1000, 16'h1fff, 16'h0010},
        '{16'h0200, 16'h02ff, 16'h0003},
        '{16'h0000, 16'hffff, 16'h0000},
        '{16'hffff, 16'h0000, 16'h0002},
        '{16'hfff0, 16'hffff, 16'hffff}
    };

    pc_bucket_profile_histogram #(
        .ADDR_BITS(ADDR_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req),
        .done(done),
        .rsp(rsp),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                tally.check_result(rsp);
            if (start && !busy)
                tally.note_request(req);
            if (cfg_valid && cfg_ready)
                tally.write_reg(cfg_index, cfg_data);
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_request(input req_t r);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        req <= r;
        do @(posedge clk); while (busy !== 1'b0);
    endtask

    task automatic send_fields(input logic [OP_W-1:0] op, input logic [PC_W-1:0] pc,
                               input logic [CYC_W-1:0] cyc, input logic [IDX_W-1:0] idx);
        req_t r;
        r.op = op;
        r.pc = pc;
        r.cycle_count = cyc;
        r.entry_index = idx;
        send_request(r);
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (tally.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [PC_W-1:0] lo, input logic [PC_W-1:0] hi,
                                 input logic [PC_W-1:0] span);
        drain();
        write_reg(CFG_RANGE_LOW, lo);
        write_reg(CFG_RANGE_HIGH, hi);
        write_reg(CFG_BUCKET_SIZE, span);
    endtask

    function automatic req_t random_request(input logic [PC_W-1:0] base);
        req_t r;
        int unsigned pick;
        r.op = OP_W'($urandom);
        r.pc = PC_W'($urandom);
        r.cycle_count = CYC_W'($urandom);
        r.entry_index = IDX_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            r.op = OP_RECORD;
            if ($urandom_range(3) != 0)
                r.pc = base + PC_W'($urandom_range(600)) - 16'd40;
            recent_pcs.push_back(r.pc);
            if (recent_pcs.size() > 16)
                void'(recent_pcs.pop_front());
        end
        else if (pick < 90)
        begin
            r.op = ($urandom_range(3) == 0) ? OP_READ_CLEAR : OP_READ;
            if (recent_pcs.size() != 0 && $urandom_range(4) != 0)
                r.entry_index = IDX_W'(tally.entry_for_pc(
                    recent_pcs[$urandom_range(recent_pcs.size() - 1)]));
            else
                r.entry_index = IDX_W'(OVF_ENTRY);
        end
        else if (pick < 96)
            r.op = $urandom_range(1) ? OP_READ_CLEAR : OP_READ;
        else
            r.op = OP_UNUSED;
        return r;
    endfunction

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_fields(OP_RECORD, 16'h0000, 8'hff, '0);
        send_fields(OP_RECORD, 16'h0000, 8'h00, '1);
        send_fields(OP_RECORD, 16'hffff, 8'hff, '0);
        send_fields(OP_READ, 16'hffff, 8'hff, 17'h00000);
        send_fields(OP_READ, 16'h0000, 8'h00, 17'h0ffff);
        send_fields(OP_READ_CLEAR, 16'h0000, 8'h00, 17'h00000);
        send_fields(OP_READ, 16'h0000, 8'h00, 17'h00000);
        send_fields(OP_READ, 16'h0000, 8'h00, 17'h10000);
        send_fields(OP_READ, 16'h0000, 8'h00, 17'h10001);
        send_fields(OP_READ_CLEAR, 16'hffff, 8'hff, 17'h1ffff);
        send_fields(OP_UNUSED, 16'hffff, 8'hff, 17'h1ffff);
        send_fields(OP_READ_CLEAR, 16'h0000, 8'h00, 17'h0ffff);

        // With the low bound above the high bound every record lands in overflow.
        apply_setting(16'h8000, 16'h7fff, 16'h0000);
        send_fields(OP_RECORD, 16'h1234, 8'h07, '0);
        send_fields(OP_RECORD, 16'hffff, 8'hff, '0);
        send_fields(OP_READ_CLEAR, 16'h0000, 8'h00, 17'h10000);
        send_fields(OP_READ, 16'h0000, 8'h00, 17'h10000);

        apply_setting(16'h0100, 16'hfffe, 16'hffff);
        send_fields(OP_RECORD, 16'h00ff, 8'h01, '0);
        send_fields(OP_RECORD, 16'hfffe, 8'h80, '0);
        send_fields(OP_RECORD, 16'h0100, 8'h7f, '0);
        send_fields(OP_READ_CLEAR, 16'h0000, 8'h00, 17'h00000);
        send_fields(OP_READ_CLEAR, 16'h0000, 8'h00, 17'h10000);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            apply_setting(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2]);
            recent_pcs.delete();
            gap_pct = (p == 2) ? 0 : 24;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 2)
                    drain();
                send_request(random_request(phase_cfg[p][0]));
            end
        end

        drain();
        if (tally.pending() != 0)
            tally.report_mismatch($sformatf("%0d results never arrived", tally.pending()));
        if (tally.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/pbph_pkg.sv
hdl/pbph_ram.sv
hdl/pc_bucket_profile_histogram.sv
hdl/pbph_checker.sv
tb/pc_bucket_profile_histogram_tb.sv
